// ===== design/lsa_pkg.sv =====
// Shared types and constants for the lane segment aggregator.
// Used by every module in the design folder; depends on nothing.
package lsa_pkg;

  // Default parameter values
  localparam int MAX_SEGMENTS_DEF = 512;
  localparam int SLOPE_FRAC_DEF   = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Position output width and limits
  localparam int POS_W = 13;
  localparam logic [POS_W-1:0] POS_MAX = 13'h0fff;
  localparam logic [POS_W-1:0] POS_MIN = 13'h1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND   = 3'd4;

  // Serial unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic [9:0] center_column;
    logic [9:0] image_width;
    logic [7:0] target_row;
    logic [7:0] max_slope;
    logic [9:0] error_band;
  } cfg_t;

  // One classified request as it sits in the queue
  typedef struct packed {
    logic       has_segment;
    logic       last_segment;
    logic [9:0] x_start;
    logic [7:0] y_start;
    logic [9:0] x_end;
    logic [7:0] y_end;
    logic [9:0] adx;
    logic [7:0] ady;
    logic       neg;
  } item_t;

  typedef struct packed {
    logic start;
    logic op;
  } unit_ctl_t;

endpackage

// ===== design/lsa_front.sv =====
// Front end: accepts requests and works out endpoint deltas and slope sign.
// Depends on lsa_pkg; feeds lsa_queue.
module lsa_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               has_segment,
  input  logic [9:0]         x_start,
  input  logic [7:0]         y_start,
  input  logic [9:0]         x_end,
  input  logic [7:0]         y_end,
  input  logic               last_segment,
  input  logic               q_full,
  output logic               q_push,
  output lsa_pkg::item_t     q_item
);

  logic signed [10:0] dx;
  logic signed [8:0]  dy;

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Deltas and magnitudes
  always_comb begin
    dx = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    dy = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    q_item.has_segment  = has_segment;
    q_item.last_segment = last_segment;
    q_item.x_start      = x_start;
    q_item.y_start      = y_start;
    q_item.x_end        = x_end;
    q_item.y_end        = y_end;
    q_item.adx          = dx[10] ? 10'(-dx) : dx[9:0];
    q_item.ady          = dy[8] ? 8'(-dy) : dy[7:0];
    q_item.neg          = dx[10] != dy[8];
  end

endmodule

// ===== design/lsa_queue.sv =====
// Small request queue between front and back.
// Depends on lsa_pkg for the entry type and depth.
module lsa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsa_pkg::item_t wr_item,
  input  logic           pop,
  output lsa_pkg::item_t head,
  output logic           full,
  output logic           empty
);

  localparam int AW = $clog2(lsa_pkg::QUEUE_DEPTH);

  lsa_pkg::item_t mem [lsa_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full  = count == (AW+1)'(lsa_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(lsa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(lsa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

// ===== design/lsa_serial_unit.sv =====
// Shared bit-serial unsigned multiplier and restoring divider.
// Depends on lsa_pkg for the control struct; one bit per cycle.
module lsa_serial_unit #(
  parameter int DW = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lsa_pkg::unit_ctl_t        ctl,
  input  logic [$clog2(DW+1)-1:0]   steps,
  input  logic [DW-1:0]             a,
  input  logic [DW-1:0]             b,
  output logic                      busy,
  output logic                      done,
  output logic [DW-1:0]             result
);

  localparam int SCW = $clog2(DW+1);

  logic [DW:0]    acc;
  logic [DW-1:0]  opr;
  logic [DW-1:0]  mc;
  logic [SCW-1:0] cnt;
  logic           op;
  logic [DW:0]    shifted;
  logic           fits;

  // Divide step: shift in next dividend bit and try the subtract
  always_comb begin
    shifted = {acc[DW-1:0], opr[DW-1]};
    fits    = shifted >= {1'b0, mc};
  end

  assign result = (op == lsa_pkg::OP_DIV) ? opr : acc[DW-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !ctl.start && busy && (cnt == SCW'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SCW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= '0;
      opr <= a;
      mc  <= b;
      op  <= ctl.op;
    end else if (busy) begin
      if (op == lsa_pkg::OP_DIV) begin
        acc <= fits ? shifted - {1'b0, mc} : shifted;
        opr <= {opr[DW-2:0], fits};
      end else begin
        if (opr[0]) begin
          acc <= acc + {1'b0, mc};
        end
        mc  <= {mc[DW-2:0], 1'b0};
        opr <= {1'b0, opr[DW-1:1]};
      end
    end
  end

endmodule

// ===== design/lsa_back.sv =====
// Back end: slope, side sums, line fit at frame end, mode flags, result register.
// Depends on lsa_pkg and lsa_serial_unit; pops requests from lsa_queue.
module lsa_back #(
  parameter int MAX_SEGMENTS = lsa_pkg::MAX_SEGMENTS_DEF,
  parameter int FRAC_BITS    = lsa_pkg::SLOPE_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lsa_pkg::cfg_t                  cfg,
  input  logic                           q_empty,
  input  lsa_pkg::item_t                 q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [lsa_pkg::POS_W-1:0] left_position,
  output logic signed [lsa_pkg::POS_W-1:0] right_position,
  output logic                           left_enabled,
  output logic                           right_enabled
);

  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int XW  = CW + 11;
  localparam int YW  = CW + 9;
  localparam int MW  = 8 + FRAC_BITS;
  localparam int SMW = MW + CW;
  localparam int SW  = SMW + 1;
  localparam int DW  = XW + MW + 2;
  localparam int SCW = $clog2(DW + 1);
  localparam int PW  = lsa_pkg::POS_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SWAIT = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_FIT   = 4'd3;
  localparam logic [3:0] ST_MWAIT = 4'd4;
  localparam logic [3:0] ST_PWAIT = 4'd5;
  localparam logic [3:0] ST_DWAIT = 4'd6;
  localparam logic [3:0] ST_QWAIT = 4'd7;
  localparam logic [3:0] ST_FLAGS = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]          state;
  lsa_pkg::item_t      item;
  logic                seen;
  logic                left_mode;
  logic                right_mode;
  logic                side;
  logic [CW-1:0]       cnt [2];
  logic [XW-1:0]       xt  [2];
  logic [YW-1:0]       yt  [2];
  logic [SW-1:0]       st  [2];
  logic [PW-1:0]       pos [2];
  logic [MW-1:0]       mmag;
  logic                msign;
  logic [DW-1:0]       num;

  lsa_pkg::unit_ctl_t  u_ctl;
  logic                u_start;
  logic                u_op;
  logic [SCW-1:0]      u_steps;
  logic [DW-1:0]       u_a;
  logic [DW-1:0]       u_b;
  logic                u_busy;
  logic                u_done;
  logic [DW-1:0]       u_res;

  assign u_ctl.start = u_start;
  assign u_ctl.op    = u_op;

  lsa_serial_unit #(.DW(DW)) u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (u_ctl),
    .steps  (u_steps),
    .a      (u_a),
    .b      (u_b),
    .busy   (u_busy),
    .done   (u_done),
    .result (u_res)
  );

  // Slope check and side choice for the current segment
  logic [MW-1:0]  mag;
  logic           keep;
  logic           to_l;
  logic           to_r;
  logic           add_l;
  logic           add_r;
  logic [SW-1:0]  slope;

  always_comb begin
    mag   = u_res[MW-1:0];
    keep  = (mag != '0) && (mag <= {cfg.max_slope, {FRAC_BITS{1'b0}}});
    slope = item.neg ? SW'(-{{(SW-MW){1'b0}}, mag}) : {{(SW-MW){1'b0}}, mag};
    to_l  = 1'b0;
    to_r  = 1'b0;
    if (left_mode && right_mode) begin
      to_l = item.neg && (item.x_end < cfg.center_column);
      to_r = !item.neg && (item.x_start > cfg.center_column);
    end else if (right_mode) begin
      to_r = !item.neg;
    end else if (left_mode) begin
      to_l = item.neg;
    end
    add_l = keep && to_l && (cnt[0] < CW'(MAX_SEGMENTS));
    add_r = keep && !add_l && to_r && (cnt[1] < CW'(MAX_SEGMENTS));
  end

  // Fit terms for the side under work
  logic [CW-1:0]  cnt_s;
  logic [SMW-1:0] abs_s;
  logic [CW+8:0]  two_n_tr;
  logic [DW-1:0]  term;
  logic [DW-1:0]  prod_s;
  logic [DW-1:0]  num_next;
  logic [DW-1:0]  num_abs;
  logic           q_neg;
  logic [PW-1:0]  pos_sat;
  logic [PW-1:0]  empty_pos;

  always_comb begin
    cnt_s     = cnt[side];
    abs_s     = st[side][SW-1] ? SMW'(-st[side]) : st[side][SMW-1:0];
    two_n_tr  = (CW+9)'({cnt_s, 1'b0}) * (CW+9)'(cfg.target_row);
    term      = (DW'(two_n_tr) - DW'(yt[side])) << FRAC_BITS;
    prod_s    = msign ? DW'(-u_res) : u_res;
    num_next  = prod_s + term;
    num_abs   = num[DW-1] ? DW'(-num) : num;
    q_neg     = num[DW-1] ^ msign;
    empty_pos = side ? PW'(cfg.image_width) : '0;
    if (q_neg) begin
      pos_sat = (u_res > DW'(4096)) ? lsa_pkg::POS_MIN : PW'(-u_res[PW-1:0]);
    end else begin
      pos_sat = (u_res > DW'(4095)) ? lsa_pkg::POS_MAX : u_res[PW-1:0];
    end
  end

  // Serial unit launch for each pass
  logic u_launch;

  assign u_launch = ((state == ST_IDLE) && !q_empty && q_head.has_segment &&
                     (q_head.adx != '0))
                 || ((state == ST_FIT) && (cnt_s != '0))
                 || ((state == ST_MWAIT) && u_done && (u_res[MW-1:0] != '0))
                 || ((state == ST_PWAIT) && u_done)
                 || ((state == ST_DWAIT) && u_done);

  // Mode update from the two positions
  logic signed [PW+1:0] dev;
  logic signed [PW+1:0] band;

  always_comb begin
    dev  = (PW+2)'($signed(pos[0])) + (PW+2)'($signed(pos[1]))
         - $signed({5'b0, cfg.image_width});
    band = $signed({5'b0, cfg.error_band});
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seen       <= 1'b0;
      left_mode  <= 1'b1;
      right_mode <= 1'b1;
      side       <= 1'b0;
      out_valid  <= 1'b0;
      u_start    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        cnt[i] <= '0;
        xt[i]  <= '0;
        yt[i]  <= '0;
        st[i]  <= '0;
      end
    end else begin
      u_start <= u_launch;
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            item <= q_head;
            if (q_head.has_segment) begin
              seen <= 1'b1;
            end
            if (q_head.has_segment && q_head.adx != '0) begin
              u_op    <= lsa_pkg::OP_DIV;
              u_a     <= DW'(q_head.ady) << (DW - 8);
              u_b     <= DW'(q_head.adx);
              u_steps <= SCW'(MW);
              state   <= ST_SWAIT;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_SWAIT: begin
          if (u_done) begin
            if (add_l) begin
              cnt[0] <= cnt[0] + 1'b1;
              xt[0]  <= xt[0] + XW'(item.x_start) + XW'(item.x_end);
              yt[0]  <= yt[0] + YW'(item.y_start) + YW'(item.y_end);
              st[0]  <= st[0] + slope;
            end else if (add_r) begin
              cnt[1] <= cnt[1] + 1'b1;
              xt[1]  <= xt[1] + XW'(item.x_start) + XW'(item.x_end);
              yt[1]  <= yt[1] + YW'(item.y_start) + YW'(item.y_end);
              st[1]  <= st[1] + slope;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!item.last_segment) begin
            state <= ST_IDLE;
          end else if (!seen) begin
            pos[0] <= '0;
            pos[1] <= '0;
            state  <= ST_OUT;
          end else begin
            side  <= 1'b0;
            state <= ST_FIT;
          end
        end
        ST_FIT: begin
          if (cnt_s == '0) begin
            pos[side] <= empty_pos;
            side      <= 1'b1;
            state     <= side ? ST_FLAGS : ST_FIT;
          end else begin
            // mean slope
            u_op    <= lsa_pkg::OP_DIV;
            u_a     <= DW'(abs_s) << (DW - SMW);
            u_b     <= DW'(cnt_s);
            u_steps <= SCW'(SMW);
            msign   <= st[side][SW-1];
            state   <= ST_MWAIT;
          end
        end
        ST_MWAIT: begin
          if (u_done) begin
            mmag <= u_res[MW-1:0];
            if (u_res[MW-1:0] == '0) begin
              pos[side] <= empty_pos;
              side      <= 1'b1;
              state     <= side ? ST_FLAGS : ST_FIT;
            end else begin
              // X * |m|
              u_op    <= lsa_pkg::OP_MUL;
              u_a     <= DW'(xt[side]);
              u_b     <= DW'(u_res[MW-1:0]);
              u_steps <= SCW'(XW);
              state   <= ST_PWAIT;
            end
          end
        end
        ST_PWAIT: begin
          if (u_done) begin
            num     <= num_next;
            // 2n * |m|
            u_op    <= lsa_pkg::OP_MUL;
            u_a     <= DW'({cnt_s, 1'b0});
            u_b     <= DW'(mmag);
            u_steps <= SCW'(CW + 1);
            state   <= ST_DWAIT;
          end
        end
        ST_DWAIT: begin
          if (u_done) begin
            u_op    <= lsa_pkg::OP_DIV;
            u_a     <= num_abs;
            u_b     <= u_res;
            u_steps <= SCW'(DW);
            state   <= ST_QWAIT;
          end
        end
        ST_QWAIT: begin
          if (u_done) begin
            pos[side] <= pos_sat;
            side      <= 1'b1;
            state     <= side ? ST_FLAGS : ST_FIT;
          end
        end
        ST_FLAGS: begin
          if (dev > band) begin
            left_mode  <= 1'b1;
            right_mode <= 1'b0;
          end else if (dev < -band) begin
            left_mode  <= 1'b0;
            right_mode <= 1'b1;
          end else begin
            left_mode  <= 1'b1;
            right_mode <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            seen      <= 1'b0;
            for (int i = 0; i < 2; i++) begin
              cnt[i] <= '0;
              xt[i]  <= '0;
              yt[i]  <= '0;
              st[i]  <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      left_position  <= pos[0];
      right_position <= pos[1];
      left_enabled   <= left_mode;
      right_enabled  <= right_mode;
    end
  end

`ifndef SYNTH
  a_unit_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    u_ctl.start |-> !u_busy) else $error("serial unit started while busy");
  a_mode_never_none: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (left_mode || right_mode)) else $error("both mode flags clear");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (cnt[0] <= CW'(MAX_SEGMENTS) && cnt[1] <= CW'(MAX_SEGMENTS)))
    else $error("side count beyond limit");
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!out_valid || !out_stall)) |=> (cnt[0] == '0 && !seen))
    else $error("frame sums not cleared after result");
`endif

endmodule

// ===== design/lane_segment_aggregator.sv =====
// Top level of the lane segment aggregator: config registers, front, queue, back.
// Depends on lsa_pkg, lsa_front, lsa_queue, lsa_back.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+------------------
//  in       | has_segment x_start y_start x_end y_end  | in_valid/in_stall
//           | last_segment                             |
//  out      | left_position right_position             | out_valid/out_stall
//           | left_enabled right_enabled               |
//  cfg      | cfg_index cfg_data                       | cfg_valid/cfg_ready
//
// A segment with a nonzero x delta gets its slope from the bit-serial divider of the shared unit.
// A frame-end item after segments adds the line fit on the same unit: per side with segments,
// up to four passes in order (mean slope, x product, denominator, quotient).
// A four-entry queue takes requests while the back end works; the output register lets
// the back end run on into the next frame while out_stall holds a result.
// rst is synchronous; it loads the register defaults and sets both mode flags.
module lane_segment_aggregator #(
  parameter int MAX_SEGMENTS    = lsa_pkg::MAX_SEGMENTS_DEF,
  parameter int SLOPE_FRAC_BITS = lsa_pkg::SLOPE_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             has_segment,
  input  logic [9:0]                       x_start,
  input  logic [7:0]                       y_start,
  input  logic [9:0]                       x_end,
  input  logic [7:0]                       y_end,
  input  logic                             last_segment,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [lsa_pkg::POS_W-1:0] left_position,
  output logic signed [lsa_pkg::POS_W-1:0] right_position,
  output logic                             left_enabled,
  output logic                             right_enabled,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lsa_pkg::cfg_t  cfg;
  lsa_pkg::item_t f_item;
  lsa_pkg::item_t q_head;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_column <= 10'd320;
      cfg.image_width   <= 10'd640;
      cfg.target_row    <= 8'd60;
      cfg.max_slope     <= 8'd10;
      cfg.error_band    <= 10'd128;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsa_pkg::REG_CENTER: cfg.center_column <= cfg_data;
        lsa_pkg::REG_WIDTH:  cfg.image_width   <= cfg_data;
        lsa_pkg::REG_ROW:    cfg.target_row    <= cfg_data[7:0];
        lsa_pkg::REG_SLOPE:  cfg.max_slope     <= cfg_data[7:0];
        lsa_pkg::REG_BAND:   cfg.error_band    <= cfg_data;
        default: ;
      endcase
    end
  end

  lsa_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .has_segment  (has_segment),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .last_segment (last_segment),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (f_item)
  );

  lsa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  lsa_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .FRAC_BITS    (SLOPE_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .left_position  (left_position),
    .right_position (right_position),
    .left_enabled   (left_enabled),
    .right_enabled  (right_enabled)
  );

endmodule
